>>> hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> hw/rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int DRIVE_COUNT  = 4;
  localparam int IMAGE_BYTES  = 262144;
  localparam int BUFFER_BYTES = 512;

  localparam int DRV_W     = $clog2(DRIVE_COUNT);
  localparam int IMG_AW    = $clog2(IMAGE_BYTES);
  localparam int MEM_DEPTH = DRIVE_COUNT * IMAGE_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int BUF_AW    = $clog2(BUFFER_BYTES);
  localparam int CNT_W     = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W     = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW      = $clog2(QUEUE_DEPTH);
  localparam int Q_CW      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_SEND  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  localparam logic [2:0] REG_LOADED   = 3'd0;
  localparam logic [2:0] REG_WRITABLE = 3'd1;
  localparam logic [2:0] REG_TOTAL_LO = 3'd2;
  localparam logic [2:0] REG_TOTAL_HI = 3'd3;
  localparam logic [2:0] REG_FORMAT   = 3'd4;
  localparam logic [2:0] REG_SKIPS    = 3'd5;

  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_N = 8'h4e;
  localparam logic [7:0] CMD_STATUS = 8'h53;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] CMD_PUT    = 8'h50;
  localparam logic [7:0] CMD_FMT_SD = 8'h21;
  localparam logic [7:0] CMD_FMT_DD = 8'h22;

  localparam logic [7:0] ST_SPT26    = 8'h80;
  localparam logic [7:0] ST_DD       = 8'h20;
  localparam logic [7:0] ST_WRITABLE = 8'h04;
  localparam logic [7:0] ST_LOADED   = 8'hff;
  localparam logic [7:0] ST_EMPTY    = 8'h7f;
  localparam logic [7:0] ST_BYTE3    = 8'he0;
  localparam logic [7:0] ST_BYTE4    = 8'h00;

  localparam logic [12:0] DLY_FIRST = 13'(200 * 40);
  localparam logic [12:0] DLY_EARLY = 13'(4 * 40);
  localparam logic [12:0] DLY_NEXT  = 13'(2 * 40);
  localparam logic [12:0] DLY_CMD   = 13'(10 * 40);
  localparam logic [12:0] DLY_WRITE = 13'(80 * 40);

  localparam logic [LEN_W-1:0] LEN_SD = LEN_W'(128);
  localparam logic [LEN_W-1:0] LEN_DD = LEN_W'(256);
  localparam logic [BUF_AW-1:0] DATA_START = BUF_AW'(5);
  localparam logic [CNT_W-1:0] CMD_FRAME_LEN = CNT_W'(5);

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data_byte;
    logic        attention;
    logic [1:0]  load_drive;
    logic [17:0] load_address;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        ready_request;
    logic [12:0] ready_delay;
    logic        reply_pending;
  } out_t;

  typedef struct packed {
    logic [3:0]  drive_loaded_mask;
    logic [3:0]  drive_writable_mask;
    logic [31:0] sector_total_pair_low;
    logic [31:0] sector_total_pair_high;
    logic [11:0] format_flags;
    logic [31:0] header_skips;
  } cfg_t;

  typedef enum logic [2:0] {
    CL_OPEN, CL_CLOSE, CL_SEND, CL_READ, CL_LOAD, CL_NONE
  } cls_t;

  typedef struct packed {
    cls_t cls;
    in_t  payload;
  } item_t;

  function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] d);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, d};
    return t[7:0] + {7'd0, t[8]};
  endfunction

endpackage

>>> hw/rtl/sfd_ram.sv
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sfd_front.sv
module sfd_front import sfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  in_t   in_data,
  output logic  busy,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t           entry_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r;
  logic            push;
  cls_t            cls;

  always_comb begin
    case (in_data.op)
      OP_OPEN:  cls = CL_OPEN;
      OP_CLOSE: cls = CL_CLOSE;
      OP_SEND:  cls = CL_SEND;
      OP_READ:  cls = CL_READ;
      OP_LOAD:  cls = CL_LOAD;
      default:  cls = CL_NONE;
    endcase
  end

  assign busy    = (count_r == Q_CW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= '{cls: cls, payload: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + Q_CW'(push) - Q_CW'(q_pop);
    end
  end

endmodule

>>> hw/rtl/sfd_back.sv
module sfd_back import sfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  output out_t  out_data
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXEC = 9'b000000010,
    ST_DFRM = 9'b000000100,
    ST_RDWT = 9'b000001000,
    ST_STAT = 9'b000010000,
    ST_HEAD = 9'b000100000,
    ST_COPY = 9'b001000000,
    ST_TAIL = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {CP_READ, CP_ZERO, CP_WRITE} copy_t;
  typedef enum logic [1:0] {TL_SUM, TL_C, TL_E} tail_t;

  state_t state_r, state_nxt;
  item_t  item_r, item_nxt;
  logic [CNT_W-1:0] frame_rem_r, frame_rem_nxt, frame_off_r, frame_off_nxt;
  logic [7:0] frame_sum_r, frame_sum_nxt;
  logic [7:0] hdr_r [4];
  logic       hdr_we;
  logic [CNT_W-1:0] reply_cnt_r, reply_cnt_nxt, reply_off_r, reply_off_nxt;
  logic [7:0] reply_sum_r, reply_sum_nxt;
  logic       ev_req_r, ev_req_nxt;
  logic [12:0] ev_dly_r, ev_dly_nxt;
  logic [7:0] rb_r, rb_nxt;
  logic [2:0] step_r, step_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt, len_r, len_nxt, pipe_idx_r, pipe_idx_nxt;
  logic       pipe_v_r, pipe_v_nxt;
  logic [IMG_AW-1:0] base_r, base_nxt;
  logic [DRV_W-1:0]  drv_r, drv_nxt;
  copy_t copy_r, copy_nxt;
  tail_t tail_r, tail_nxt;

  logic clr, push_en, push_summed;
  logic [7:0] push_byte;

  logic              fb_we;
  logic [BUF_AW-1:0] fb_waddr, fb_raddr;
  logic [7:0]        fb_rdata;
  logic              rp_we;
  logic [BUF_AW-1:0] rp_waddr, rp_raddr;
  logic [7:0]        rp_wdata, rp_rdata;
  logic              im_we;
  logic [MEM_AW-1:0] im_waddr, im_raddr;
  logic [7:0]        im_wdata, im_rdata;

  // frame header decode
  logic [7:0]        drv_raw;
  logic              drv_ok;
  logic [DRV_W-1:0]  drv;
  logic [15:0]       sec, total;
  logic [31:0]       pair;
  logic              sec256, spt26, boot256, boot_sec, sec_bad;
  logic [LEN_W-1:0]  xfer_len;
  logic [IMG_AW-1:0] s_img, base, skip;
  logic [7:0]        status;
  logic              issue;

  always_comb begin
    drv_raw = hdr_r[0] - CH_1;
    drv_ok  = (drv_raw < 8'(DRIVE_COUNT)) && (drv_raw < 8'd4);
    drv     = drv_raw[DRV_W-1:0];
    sec     = {hdr_r[3], hdr_r[2]};
    pair    = drv[1] ? cfg.sector_total_pair_high : cfg.sector_total_pair_low;
    total   = drv[0] ? pair[31:16] : pair[15:0];
    sec256  = cfg.format_flags[drv];
    spt26   = cfg.format_flags[4 + drv];
    boot256 = cfg.format_flags[8 + drv] && sec256;
    boot_sec = (sec < 16'd4);
    sec_bad = (sec == 16'd0) || (sec > total);
    xfer_len = (!boot_sec && sec256) ? LEN_DD : LEN_SD;
    s_img   = IMG_AW'(sec);
    skip    = IMG_AW'(cfg.header_skips[8*drv +: 8]);
    if (boot_sec) begin
      base = boot256 ? ((s_img - 1'b1) << 8) : ((s_img - 1'b1) << 7);
    end else begin
      base = (boot256 ? IMG_AW'(3 * 256) : IMG_AW'(3 * 128))
           + (sec256 ? ((s_img - IMG_AW'(4)) << 8) : ((s_img - IMG_AW'(4)) << 7));
    end
    base = base + skip;
    status = spt26 ? ST_SPT26 : (sec256 ? ST_DD : 8'h00);
    if (cfg.drive_writable_mask[drv]) begin
      status = status | ST_WRITABLE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    frame_rem_nxt = frame_rem_r;
    frame_off_nxt = frame_off_r;
    frame_sum_nxt = frame_sum_r;
    reply_cnt_nxt = reply_cnt_r;
    reply_off_nxt = reply_off_r;
    reply_sum_nxt = reply_sum_r;
    ev_req_nxt    = ev_req_r;
    ev_dly_nxt    = ev_dly_r;
    rb_nxt        = rb_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    pipe_idx_nxt  = pipe_idx_r;
    pipe_v_nxt    = pipe_v_r;
    base_nxt      = base_r;
    drv_nxt       = drv_r;
    copy_nxt      = copy_r;
    tail_nxt      = tail_r;
    clr           = 1'b0;
    push_en       = 1'b0;
    push_summed   = 1'b0;
    push_byte     = 8'h00;
    q_pop         = 1'b0;
    hdr_we        = 1'b0;
    fb_we         = 1'b0;
    fb_waddr      = frame_off_r[BUF_AW-1:0];
    fb_raddr      = DATA_START + idx_r[BUF_AW-1:0];
    rp_raddr      = reply_off_r[BUF_AW-1:0];
    im_we         = 1'b0;
    im_waddr      = {drv_r, base_r + IMG_AW'(pipe_idx_r)};
    im_wdata      = fb_rdata;
    im_raddr      = {drv_r, base_r + IMG_AW'(idx_r)};
    issue         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          item_nxt   = q_item;
          ev_req_nxt = 1'b0;
          ev_dly_nxt = '0;
          rb_nxt     = 8'h00;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (item_r.cls)
          CL_OPEN: begin
            frame_sum_nxt = 8'h00;
            frame_off_nxt = '0;
            frame_rem_nxt = CMD_FRAME_LEN;
          end
          CL_CLOSE: begin
            if (frame_off_r != '0) begin
              clr        = 1'b1;
              ev_req_nxt = 1'b1;
              ev_dly_nxt = DLY_CMD;
              if (frame_sum_r != 8'h00) begin
                push_en   = 1'b1;
                push_byte = CH_E;
              end else if (drv_ok) begin
                push_en  = 1'b1;
                drv_nxt  = drv;
                base_nxt = base;
                case (hdr_r[1])
                  CMD_STATUS: begin
                    push_byte = CH_A;
                    step_nxt  = '0;
                    state_nxt = ST_STAT;
                  end
                  CMD_READ: begin
                    if (sec_bad) begin
                      push_byte = CH_E;
                    end else begin
                      push_byte = CH_A;
                      len_nxt   = xfer_len;
                      copy_nxt  = CP_READ;
                      tail_nxt  = TL_SUM;
                      state_nxt = ST_HEAD;
                    end
                  end
                  CMD_WRITE, CMD_PUT: begin
                    push_byte     = CH_A;
                    frame_sum_nxt = 8'h00;
                    frame_rem_nxt = CNT_W'(((boot_sec ? boot256 : sec256) ? LEN_DD : LEN_SD))
                                  + 1'b1;
                  end
                  CMD_FMT_SD, CMD_FMT_DD: begin
                    push_byte = CH_A;
                    len_nxt   = (hdr_r[1] == CMD_FMT_SD) ? LEN_SD : LEN_DD;
                    copy_nxt  = CP_ZERO;
                    tail_nxt  = TL_SUM;
                    state_nxt = ST_HEAD;
                  end
                  default: begin
                    push_byte = CH_N;
                  end
                endcase
              end
            end
          end
          CL_SEND: begin
            if (cfg.drive_loaded_mask[0] && (frame_rem_r != '0)) begin
              if (frame_off_r < CNT_W'(BUFFER_BYTES)) begin
                fb_we         = 1'b1;
                frame_off_nxt = frame_off_r + 1'b1;
                hdr_we        = (frame_off_r < CNT_W'(4));
              end
              frame_rem_nxt = frame_rem_r - 1'b1;
              if (frame_rem_r == CNT_W'(1)) begin
                frame_sum_nxt = frame_sum_r ^ item_r.payload.data_byte;
                if (item_r.payload.attention) begin
                  state_nxt = ST_DFRM;
                end
              end else begin
                frame_sum_nxt = sum_add(frame_sum_r, item_r.payload.data_byte);
              end
            end
          end
          CL_READ: begin
            if (reply_cnt_r != '0) begin
              state_nxt = ST_RDWT;
            end
          end
          CL_LOAD: begin
            im_we    = (item_r.payload.load_drive < 2'(DRIVE_COUNT - 1))
                    || (item_r.payload.load_drive == 2'(DRIVE_COUNT - 1));
            im_waddr = {item_r.payload.load_drive[DRV_W-1:0],
                        item_r.payload.load_address[IMG_AW-1:0]};
            im_wdata = item_r.payload.data_byte;
          end
          default: begin
          end
        endcase
      end
      ST_DFRM: begin
        clr        = 1'b1;
        ev_req_nxt = 1'b1;
        ev_dly_nxt = DLY_WRITE;
        push_en    = 1'b1;
        if (frame_sum_r != 8'h00) begin
          push_byte = CH_E;
          state_nxt = ST_DONE;
        end else begin
          push_byte = CH_C;
          if (!drv_ok || !cfg.drive_writable_mask[drv] || !cfg.drive_loaded_mask[drv]
              || sec_bad) begin
            tail_nxt  = TL_E;
            state_nxt = ST_TAIL;
          end else begin
            drv_nxt    = drv;
            base_nxt   = base;
            len_nxt    = xfer_len;
            copy_nxt   = CP_WRITE;
            tail_nxt   = TL_C;
            idx_nxt    = '0;
            pipe_v_nxt = 1'b0;
            state_nxt  = ST_COPY;
          end
        end
      end
      ST_RDWT: begin
        rb_nxt        = rp_rdata;
        reply_off_nxt = reply_off_r + 1'b1;
        reply_cnt_nxt = reply_cnt_r - 1'b1;
        if (reply_cnt_r == CNT_W'(1)) begin
          reply_off_nxt = '0;
        end else begin
          ev_req_nxt = 1'b1;
          ev_dly_nxt = (reply_off_r < CNT_W'(2)) ? DLY_FIRST :
                       (reply_off_r < CNT_W'(3)) ? DLY_EARLY : DLY_NEXT;
        end
        state_nxt = ST_DONE;
      end
      ST_STAT: begin
        push_en  = 1'b1;
        step_nxt = step_r + 1'b1;
        case (step_r)
          3'd0: push_byte = CH_C;
          3'd1: begin
            push_byte   = status;
            push_summed = 1'b1;
          end
          3'd2: begin
            push_byte   = cfg.drive_loaded_mask[drv_r] ? ST_LOADED : ST_EMPTY;
            push_summed = 1'b1;
          end
          3'd3: begin
            push_byte   = ST_BYTE3;
            push_summed = 1'b1;
          end
          3'd4: begin
            push_byte   = ST_BYTE4;
            push_summed = 1'b1;
          end
          default: begin
            push_byte = reply_sum_r;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_HEAD: begin
        push_en    = 1'b1;
        push_byte  = CH_C;
        idx_nxt    = '0;
        pipe_v_nxt = 1'b0;
        state_nxt  = ST_COPY;
      end
      ST_COPY: begin
        issue        = (idx_r < len_r);
        pipe_v_nxt   = issue;
        pipe_idx_nxt = idx_r;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pipe_v_r) begin
          case (copy_r)
            CP_READ: begin
              push_en     = 1'b1;
              push_byte   = im_rdata;
              push_summed = 1'b1;
            end
            CP_ZERO: begin
              push_en     = 1'b1;
              push_summed = 1'b1;
            end
            default: begin
              im_we = 1'b1;
            end
          endcase
        end
        if (!issue && !pipe_v_r) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        push_en = 1'b1;
        case (tail_r)
          TL_SUM:  push_byte = reply_sum_r;
          TL_C:    push_byte = CH_C;
          default: push_byte = CH_E;
        endcase
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (clr) begin
      reply_cnt_nxt = '0;
      reply_off_nxt = '0;
      reply_sum_nxt = 8'h00;
    end
    rp_we    = push_en && (reply_cnt_nxt < CNT_W'(BUFFER_BYTES));
    rp_waddr = reply_cnt_nxt[BUF_AW-1:0];
    rp_wdata = push_byte;
    if (push_en) begin
      if (rp_we) begin
        reply_cnt_nxt = reply_cnt_nxt + 1'b1;
      end
      if (push_summed) begin
        reply_sum_nxt = sum_add(reply_sum_nxt, push_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[frame_off_r[1:0]] <= item_r.payload.data_byte;
    end
    item_r     <= item_nxt;
    rb_r       <= rb_nxt;
    ev_dly_r   <= ev_dly_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    len_r      <= len_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    base_r     <= base_nxt;
    drv_r      <= drv_nxt;
    copy_r     <= copy_nxt;
    tail_r     <= tail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_rem_r <= '0;
      frame_off_r <= '0;
      frame_sum_r <= 8'h00;
      reply_cnt_r <= '0;
      reply_off_r <= '0;
      reply_sum_r <= 8'h00;
      ev_req_r    <= 1'b0;
      pipe_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_rem_r <= frame_rem_nxt;
      frame_off_r <= frame_off_nxt;
      frame_sum_r <= frame_sum_nxt;
      reply_cnt_r <= reply_cnt_nxt;
      reply_off_r <= reply_off_nxt;
      reply_sum_r <= reply_sum_nxt;
      ev_req_r    <= ev_req_nxt;
      pipe_v_r    <= pipe_v_nxt;
    end
  end

  sfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_frame_ram (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(item_r.payload.data_byte),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  sfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_reply_ram (
    .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
    .raddr(rp_raddr), .rdata(rp_rdata)
  );

  sfd_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_image_ram (
    .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
    .raddr(im_raddr), .rdata(im_rdata)
  );

  assign out_valid              = (state_r == ST_DONE);
  assign out_data.read_byte     = rb_r;
  assign out_data.ready_request = ev_req_r;
  assign out_data.ready_delay   = ev_dly_r;
  assign out_data.reply_pending = (reply_cnt_r != '0);

endmodule

>>> hw/rtl/serial_floppy_drive_protocol_unit.sv
// Drive side of a serial floppy link for up to four drives. Items enter on
// start while busy is low and wait in a two-entry queue; every item gives
// exactly one result, shown for a single cycle on out_valid, which the
// receiver cannot hold off. A plain item passes the idle, execute and done
// states; a read popping a reply byte adds a reply-read state, a status
// command a status state, a sector read, format or completed data frame a
// head or data-frame, a copy (n = 128 or 256 sector bytes; image memory moves
// one byte per cycle) and a tail state. A refused data frame adds data-frame
// and tail states, a bad check only data-frame. busy rises only while the
// queue is full. Configuration is written on cfg_valid (cfg_ready is always
// high); the user must write only while the unit is idle: it does not check.
module serial_floppy_drive_protocol_unit import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  item_t q_item;
  logic  dly_legal, dly_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOADED:   cfg_r.drive_loaded_mask      <= cfg_data[3:0];
        REG_WRITABLE: cfg_r.drive_writable_mask    <= cfg_data[3:0];
        REG_TOTAL_LO: cfg_r.sector_total_pair_low  <= cfg_data;
        REG_TOTAL_HI: cfg_r.sector_total_pair_high <= cfg_data;
        REG_FORMAT:   cfg_r.format_flags           <= cfg_data[11:0];
        REG_SKIPS:    cfg_r.header_skips           <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfd_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  sfd_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_valid(out_valid), .out_data(out_data)
  );

  assign dly_legal = out_data.ready_delay inside {DLY_FIRST, DLY_EARLY, DLY_NEXT, DLY_CMD,
                                                  DLY_WRITE};
  assign dly_zero  = (out_data.ready_delay == 13'd0);

  `ASSERT_CLK(a_single_beat, clk, rst_n, out_valid |=> !out_valid)
  `ASSERT_NEVER(a_req_delay, clk, rst_n, out_valid && out_data.ready_request && dly_zero)
  `ASSERT_CLK(a_delay_set, clk, rst_n, (out_valid && out_data.ready_request) |-> dly_legal)

endmodule

>>> verif/sfd_reply_checker.sv
module sfd_reply_checker import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [3:0]  loaded_m, wr_m;
  logic [31:0] tot_lo, tot_hi, skips;
  logic [11:0] fmt;

  logic [7:0]  fbuf [BUFFER_BYTES];
  int unsigned f_rem, f_off;
  logic [7:0]  f_sum;
  logic [7:0]  rbuf [BUFFER_BYTES];
  int unsigned r_cnt, r_off;
  logic [7:0]  r_sum;
  logic [7:0]  image [int unsigned];
  logic        ev_req;
  logic [12:0] ev_dly;

  out_t exp_replies[$];

  function automatic logic [7:0] carry_add(input logic [7:0] s, input logic [7:0] d);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, d};
    return t[7:0] + 8'(t[8]);
  endfunction

  function int unsigned sec_len(input int unsigned d);
    return fmt[d] ? 256 : 128;
  endfunction

  function int unsigned boot_len(input int unsigned d);
    return fmt[8 + d] ? sec_len(d) : 128;
  endfunction

  function int unsigned total_of(input int unsigned d);
    logic [31:0] p;
    p = (d < 2) ? tot_lo : tot_hi;
    return (p >> ((d & 1) * 16)) & 32'hffff;
  endfunction

  function int unsigned sector_len(input int unsigned d, input int unsigned s);
    return (s < 4) ? 128 : sec_len(d);
  endfunction

  function int unsigned sector_start(input int unsigned d, input int unsigned s);
    int unsigned a;
    if (s < 4) begin
      a = (s - 1) * boot_len(d);
    end else begin
      a = 3 * boot_len(d) + (s - 4) * sec_len(d);
    end
    return a + ((skips >> (8 * d)) & 32'hff);
  endfunction

  function int unsigned img_key(input int unsigned d, input int unsigned a);
    return d * IMAGE_BYTES + (a % IMAGE_BYTES);
  endfunction

  task push_reply(input logic [7:0] b, input bit summed);
    if (r_cnt < BUFFER_BYTES) begin
      rbuf[r_cnt] = b;
      r_cnt++;
    end
    if (summed) r_sum = carry_add(r_sum, b);
  endtask

  task clear_reply(input logic [12:0] dly);
    r_sum = 0;
    r_off = 0;
    r_cnt = 0;
    ev_req = 1;
    ev_dly = dly;
  endtask

  task close_command();
    int unsigned d, s, n, a;
    logic [7:0] dc, st;
    if (f_off == 0) return;
    clear_reply(DLY_CMD);
    if (f_sum != 0) begin
      push_reply(CH_E, 0);
      return;
    end
    dc = fbuf[0] - CH_1;
    d = dc;
    if (d >= DRIVE_COUNT) return;
    s = fbuf[2] + 256 * fbuf[3];
    case (fbuf[1])
      CMD_STATUS: begin
        st = fmt[4 + d] ? ST_SPT26 : (fmt[d] ? ST_DD : '0);
        if (wr_m[d]) st = st | ST_WRITABLE;
        push_reply(CH_A, 0);
        push_reply(CH_C, 0);
        push_reply(st, 1);
        push_reply(loaded_m[d] ? ST_LOADED : ST_EMPTY, 1);
        push_reply(ST_BYTE3, 1);
        push_reply(ST_BYTE4, 1);
        push_reply(r_sum, 0);
      end
      CMD_READ: begin
        if (s < 1 || s > total_of(d)) begin
          push_reply(CH_E, 0);
        end else begin
          push_reply(CH_A, 0);
          push_reply(CH_C, 0);
          n = sector_len(d, s);
          a = sector_start(d, s);
          for (int unsigned i = 0; i < n; i++) push_reply(image[img_key(d, a + i)], 1);
          push_reply(r_sum, 0);
        end
      end
      CMD_WRITE, CMD_PUT: begin
        push_reply(CH_A, 0);
        f_sum = 0;
        f_rem = ((s < 4) ? boot_len(d) : sec_len(d)) + 1;
      end
      CMD_FMT_SD, CMD_FMT_DD: begin
        n = (fbuf[1] == CMD_FMT_SD) ? 128 : 256;
        push_reply(CH_A, 0);
        push_reply(CH_C, 0);
        for (int unsigned i = 0; i < n; i++) push_reply('0, 1);
        push_reply(r_sum, 0);
      end
      default: push_reply(CH_N, 0);
    endcase
  endtask

  task store_sector();
    int unsigned d, s, n, a;
    logic [7:0] dc;
    clear_reply(DLY_WRITE);
    if (f_sum != 0) begin
      push_reply(CH_E, 0);
      return;
    end
    push_reply(CH_C, 0);
    dc = fbuf[0] - CH_1;
    d = dc;
    if (d >= DRIVE_COUNT || !wr_m[d] || !loaded_m[d]) begin
      push_reply(CH_E, 0);
      return;
    end
    s = fbuf[2] + 256 * fbuf[3];
    if (s < 1 || s > total_of(d)) begin
      push_reply(CH_E, 0);
      return;
    end
    n = sector_len(d, s);
    a = sector_start(d, s);
    for (int unsigned i = 0; i < n; i++) image[img_key(d, a + i)] = fbuf[(5 + i) % BUFFER_BYTES];
    push_reply(CH_C, 0);
  endtask

  task predict_reply(input in_t x, output out_t y);
    logic [7:0]  rb;
    logic [12:0] dl;
    ev_req = 0;
    ev_dly = 0;
    rb = 0;
    case (x.op)
      OP_OPEN: begin
        f_sum = 0;
        f_off = 0;
        f_rem = 5;
      end
      OP_CLOSE: close_command();
      OP_SEND: begin
        if (loaded_m[0] && f_rem != 0) begin
          if (f_off < BUFFER_BYTES) begin
            fbuf[f_off] = x.data_byte;
            f_off++;
          end
          f_rem--;
          if (f_rem == 0) begin
            f_sum = f_sum ^ x.data_byte;
            if (x.attention) store_sector();
          end else begin
            f_sum = carry_add(f_sum, x.data_byte);
          end
        end
      end
      OP_READ: begin
        if (r_cnt != 0) begin
          rb = rbuf[r_off % BUFFER_BYTES];
          dl = (r_off < 2) ? DLY_FIRST : (r_off < 3) ? DLY_EARLY : DLY_NEXT;
          r_off++;
          r_cnt--;
          if (r_cnt == 0) begin
            r_off = 0;
          end else begin
            ev_req = 1;
            ev_dly = dl;
          end
        end
      end
      OP_LOAD: image[img_key(x.load_drive, x.load_address)] = x.data_byte;
      default: ;
    endcase
    y.read_byte = rb;
    y.ready_request = ev_req;
    y.ready_delay = ev_dly;
    y.reply_pending = (r_cnt != 0);
  endtask

  task flag_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t want, got;
    if (!rst_n) begin
      loaded_m = 0; wr_m = 0; tot_lo = 0; tot_hi = 0; fmt = 0; skips = 0;
      f_rem = 0; f_off = 0; f_sum = 0;
      r_cnt = 0; r_off = 0; r_sum = 0;
      exp_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOADED:   loaded_m = cfg_data[3:0];
          REG_WRITABLE: wr_m = cfg_data[3:0];
          REG_TOTAL_LO: tot_lo = cfg_data;
          REG_TOTAL_HI: tot_hi = cfg_data;
          REG_FORMAT:   fmt = cfg_data[11:0];
          REG_SKIPS:    skips = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        got = out_data;
        if (exp_replies.size() == 0) begin
          $display("%0t: result beat with nothing expected", $realtime);
          fails++;
        end else begin
          want = exp_replies.pop_front();
          if (got.read_byte !== want.read_byte)
            flag_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.ready_request !== want.ready_request)
            flag_mismatch("ready_request", got.ready_request, want.ready_request);
          if (got.ready_delay !== want.ready_delay)
            flag_mismatch("ready_delay", got.ready_delay, want.ready_delay);
          if (got.reply_pending !== want.reply_pending)
            flag_mismatch("reply_pending", got.reply_pending, want.reply_pending);
        end
      end
      if (start && !busy) begin
        predict_reply(in_data, want);
        exp_replies.push_back(want);
      end
    end
    pending = exp_replies.size();
  end
endmodule

>>> verif/tb.sv
module tb;
  import sfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n, start, busy, out_valid;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  in_t         in_data;
  out_t        out_data;
  int          fails, pending;

  bit          written [int unsigned];
  int          sent;
  bit          steady;

  serial_floppy_drive_protocol_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sfd_reply_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fails, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_t mk(input logic [2:0] op, input logic [7:0] b, input logic att);
    in_t x;
    x.op = op;
    x.data_byte = b;
    x.attention = att;
    x.load_drive = 2'($urandom);
    x.load_address = 18'($urandom);
    return x;
  endfunction

  task automatic put(input in_t x);
    if (!steady) begin
      while ($urandom_range(99) < 13) begin
        start = 0;
        @(negedge clk);
      end
    end
    start = 1;
    in_data = x;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic load_byte(input int unsigned d, input int unsigned a, input logic [7:0] b);
    in_t x;
    x = mk(OP_LOAD, b, 1'($urandom));
    x.load_drive = 2'(d);
    x.load_address = 18'(a);
    put(x);
    written[d * IMAGE_BYTES + (a % IMAGE_BYTES)] = 1;
  endtask

  task automatic frame(input logic [7:0] dev, input logic [7:0] code,
                       input logic [15:0] s, input bit bad);
    logic [7:0] b [4];
    logic [7:0] acc;
    b = '{dev, code, s[7:0], s[15:8]};
    acc = 0;
    put(mk(OP_OPEN, 8'($urandom), 1'($urandom)));
    foreach (b[i]) begin
      acc = u_chk.carry_add(acc, b[i]);
      put(mk(OP_SEND, b[i], 1'($urandom)));
    end
    if (bad) acc = acc ^ 8'($urandom_range(1, 255));
    put(mk(OP_SEND, acc, 0));
    put(mk(OP_CLOSE, 8'($urandom), 1'($urandom)));
  endtask

  task automatic read_n(input int n);
    repeat (n) put(mk(OP_READ, 8'($urandom), 1'($urandom)));
  endtask

  // make sure a sector read never touches image bytes that were never written
  task automatic read_sector(input int unsigned d, input int unsigned s);
    int unsigned a, n;
    bit hit;
    hit = (s >= 1 && s <= u_chk.total_of(d));
    if (hit) begin
      a = u_chk.sector_start(d, s);
      n = u_chk.sector_len(d, s);
      for (int unsigned i = 0; i < n; i++)
        if (!written.exists(d * IMAGE_BYTES + ((a + i) % IMAGE_BYTES)))
          load_byte(d, a + i, 8'($urandom));
    end
    frame(CH_1 + 8'(d), CMD_READ, 16'(s), 0);
    read_n(hit && u_chk.loaded_m[0] ? n + 3 + $urandom_range(1) : 1 + $urandom_range(1));
  endtask

  task automatic write_sector(input int unsigned d, input int unsigned s, input bit bad);
    int unsigned len, n, a;
    logic [7:0] acc, b;
    logic [7:0] data [$];
    bit att, ok;
    frame(CH_1 + 8'(d), $urandom_range(1) ? CMD_WRITE : CMD_PUT, 16'(s), 0);
    len = (s < 4) ? u_chk.boot_len(d) : u_chk.sec_len(d);
    acc = 0;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      data.push_back(b);
      acc = u_chk.carry_add(acc, b);
      put(mk(OP_SEND, b, 1'($urandom)));
    end
    if (bad) acc = acc ^ 8'($urandom_range(1, 255));
    att = ($urandom_range(9) != 0);
    put(mk(OP_SEND, acc, att));
    ok = att && !bad && u_chk.loaded_m[0] && u_chk.loaded_m[d] && u_chk.wr_m[d] &&
         s >= 1 && s <= u_chk.total_of(d);
    if (ok) begin
      a = u_chk.sector_start(d, s);
      n = u_chk.sector_len(d, s);
      for (int unsigned i = 0; i < n; i++) written[d * IMAGE_BYTES + ((a + i) % IMAGE_BYTES)] = 1;
    end
    read_n(3);
  endtask

  function automatic int unsigned pick_sector(input int unsigned d);
    int unsigned r, t;
    r = $urandom_range(99);
    t = u_chk.total_of(d);
    if (r < 10) return 0;
    if (r < 15) return (t + 1) & 16'hffff;
    if (r < 20) return $urandom_range(1, (t > 0) ? t : 1);
    return $urandom_range(1, 6);
  endfunction

  task automatic set_config(input logic [3:0] l, input logic [3:0] w, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [11:0] f, input logic [31:0] sk);
    cfg_write(REG_LOADED, 32'(l));
    cfg_write(REG_WRITABLE, 32'(w));
    cfg_write(REG_TOTAL_LO, lo);
    cfg_write(REG_TOTAL_HI, hi);
    cfg_write(REG_FORMAT, 32'(f));
    cfg_write(REG_SKIPS, sk);
  endtask

  task automatic noise();
    in_t x;
    logic [7:0] b;
    repeat (6) begin
      x = mk(3'($urandom), 8'($urandom), 1'($urandom));
      if (x.op == OP_SEND) begin
        // keep stray beats from forming a frame that names a real drive
        do b = 8'($urandom); while (b >= CH_1 && b < CH_1 + DRIVE_COUNT);
        x.data_byte = b;
      end
      put(x);
      if (x.op == OP_LOAD) written[x.load_drive * IMAGE_BYTES + x.load_address] = 1;
    end
  endtask

  task automatic random_beats(input int budget);
    int stop, k;
    int unsigned d;
    logic [7:0] dev, code;
    stop = sent + budget;
    while (sent < stop) begin
      k = $urandom_range(99);
      d = $urandom_range(DRIVE_COUNT - 1);
      if (k < 30) read_sector(d, pick_sector(d));
      else if (k < 50) write_sector(d, pick_sector(d), $urandom_range(9) == 0);
      else if (k < 58) begin
        frame(CH_1 + 8'(d), CMD_STATUS, 16'($urandom), 0);
        read_n(7 + $urandom_range(1));
      end else if (k < 64) begin
        code = $urandom_range(1) ? CMD_FMT_SD : CMD_FMT_DD;
        frame(CH_1 + 8'(d), code, 16'($urandom), 0);
        read_n(code == CMD_FMT_SD ? 131 : 259);
      end else if (k < 68) begin
        frame(CH_1 + 8'(d), 8'($urandom), 16'($urandom), 0);
        read_n(1);
      end else if (k < 72) begin
        do dev = 8'($urandom); while (dev >= CH_1 && dev < CH_1 + DRIVE_COUNT);
        frame(dev, CMD_READ, 16'd1, 0);
        read_n(1);
      end else if (k < 76) begin
        frame(CH_1 + 8'(d), CMD_READ, 16'(pick_sector(d)), 1);
        read_n(1);
      end else if (k < 80) begin
        put(mk(OP_OPEN, 8'($urandom), 1'($urandom)));
        put(mk(OP_CLOSE, 8'($urandom), 1'($urandom)));
      end else if (k < 85) load_byte(d, $urandom, 8'($urandom));
      else if (k < 92) noise();
      else read_n($urandom_range(1, 4));
    end
  endtask

  initial begin
    logic [31:0] lo, hi;
    rst_n = 0;
    start = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_LOADED;
    cfg_data = 0;
    sent = 0;
    steady = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // fill the frame store up to its longest sector once so later decodes never see unwritten bytes
    set_config(4'b0001, 4'b0000, 32'h0, 32'h0, 12'h001, 32'h0);
    frame(CH_1, CMD_WRITE, 16'd4, 0);
    repeat (257) put(mk(OP_SEND, 8'($urandom), 0));
    read_n(2);
    drain();

    set_config(4'b1011, 4'b0011, {16'd8, 16'd12}, {16'hffff, 16'd3}, 12'h3a5, 32'hff00_0401);
    frame(CH_1 + 8'd1, CMD_STATUS, 16'd0, 0);
    read_n(7);
    read_sector(0, 0);
    write_sector(3, 2, 0);
    frame(CH_1, CMD_FMT_SD, 16'd0, 0);
    read_n(131);
    frame(CH_1, 8'h58, 16'd0, 0);
    read_n(1);
    frame(8'h39, CMD_STATUS, 16'd0, 0);
    frame(CH_1, CMD_STATUS, 16'd0, 1);
    read_n(2);
    put(mk(OP_OPEN, 0, 0));
    put(mk(OP_CLOSE, 0, 0));
    for (int o = OP_LOAD + 1; o < 8; o++) put(mk(3'(o), 8'hff, 1));
    load_byte(3, 18'h3ffff, 8'hff);
    load_byte(0, 0, 8'h00);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_config(4'hf, 4'hf, {16'd12, 16'd12}, {16'd20, 16'd9}, 12'h0f0, 32'h0010_0300);
        1: set_config(4'hf, 4'hf, '1, '1, 12'hfff, '1);
        2: set_config(4'b0001, 4'b0000, 32'h0, {16'd0, 16'd5}, 12'h000, 32'h0);
        3: set_config(4'h0, 4'h0, 32'h0, 32'h0, 12'h000, 32'h0);
        default: begin
          lo = {16'($urandom_range(30)), 16'($urandom_range(30))};
          hi = {16'($urandom_range(30)), 16'($urandom_range(30))};
          set_config({3'($urandom), 1'b1}, 4'($urandom), lo, hi, 12'($urandom), $urandom);
        end
      endcase
      // a fresh status frame so a stray close never re-decodes an older phase's frame
      frame(CH_1, CMD_STATUS, 16'd0, 0);
      read_n(7);
      steady = (ph == 2);
      random_beats(ph == 3 ? 10 : 20);
      steady = 0;
    end

    drain();
    repeat (300) @(negedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
